>>> rtl/core/rls_pkg.sv
// rls_pkg: shared types, codes and constants of the led strip serializer
`default_nettype none

package rls_pkg;

  // default strip length and frame store geometry
  localparam int unsigned LedCountDef  = 6;
  localparam int unsigned BytesPerLed  = 3;
  localparam int unsigned IdxW         = 5;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned TickW        = 8;
  localparam int unsigned BitPosW      = 3;

  // register reset values
  localparam logic [TickW-1:0] ZeroHighRst = 8'd15;
  localparam logic [TickW-1:0] ZeroLowRst  = 8'd30;
  localparam logic [TickW-1:0] OneHighRst  = 8'd30;
  localparam logic [TickW-1:0] OneLowRst   = 8'd30;

  // top bit of a byte, sent first
  localparam logic [BitPosW-1:0] MsbPos = 3'd7;

  // item kinds
  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_ROTATE = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_START  = 3'd3,
    KIND_TICK   = 3'd4
  } kind_e;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ZERO_LOW  = 3'd1,
    CFG_ONE_HIGH  = 3'd2,
    CFG_ONE_LOW   = 3'd3
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] byte_index;
    logic [7:0]      byte_value;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic line;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_item_t;

  // per cell control
  typedef struct packed {
    logic wr;
    logic clr;
    logic shift_byte;
    logic shift_led;
  } cell_ctl_t;

  // bit timing registers
  typedef struct packed {
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
  } tick_cfg_t;

  // bit timer status
  typedef struct packed {
    logic sending;
    logic low;
    logic busy_next;
    logic done;
    logic shift;
  } tmr_status_t;

  // phase length for a bit value, zero counts as one tick
  function automatic logic [TickW-1:0] phase_len(input logic bit_val,
                                                 input logic [TickW-1:0] one_t,
                                                 input logic [TickW-1:0] zero_t);
    logic [TickW-1:0] v;
    v = bit_val ? one_t : zero_t;
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rls_cell.sv
// rls_cell: one byte cell of the frame store chain
`default_nettype none

module rls_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  rls_pkg::cell_ctl_t ctl_i,
  input  wire [7:0]       wr_data_i,
  input  wire [7:0]       next_byte_i,
  input  wire [7:0]       next_led_i,
  output logic [7:0]      data_o
);
  import rls_pkg::*;

  logic [7:0] data_d, data_q;

  // one operation per beat; the byte shift runs while a frame is sent
  always_comb begin
    data_d = data_q;
    priority if (ctl_i.clr) begin
      data_d = '0;
    end else if (ctl_i.wr) begin
      data_d = wr_data_i;
    end else if (ctl_i.shift_led) begin
      data_d = next_led_i;
    end else if (ctl_i.shift_byte) begin
      data_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/core/rls_timer.sv
// rls_timer: bit and phase sequencer of the serial waveform
`default_nettype none

module rls_timer #(
  parameter int unsigned StoreBytes = 18
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire                   tick_i,
  input  rls_pkg::tick_cfg_t    cfg_i,
  input  wire [7:0]             head_byte_i,
  input  wire                   next_msb_i,
  output rls_pkg::tmr_status_t  status_o
);
  import rls_pkg::*;

  localparam int unsigned BposW = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam logic [BposW-1:0] LastByte = BposW'(StoreBytes - 1);

  logic                 sending_d, sending_q;
  logic                 low_d, low_q;
  logic [BitPosW-1:0]   bit_d, bit_q;
  logic [BposW-1:0]     byte_d, byte_q;
  logic [TickW-1:0]     ticks_d, ticks_q;
  logic                 done, shift;
  logic [BitPosW-1:0]   bit_dec;

  assign bit_dec = bit_q - BitPosW'(1);

  // phase sequencing
  always_comb begin
    sending_d = sending_q;
    low_d     = low_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    ticks_d   = ticks_q;
    done      = 1'b0;
    shift     = 1'b0;
    if (start_i) begin
      sending_d = 1'b1;
      byte_d    = '0;
      bit_d     = MsbPos;
      low_d     = 1'b0;
      ticks_d   = phase_len(head_byte_i[MsbPos], cfg_i.one_high, cfg_i.zero_high);
    end else if (tick_i && sending_q) begin
      if (ticks_q > TickW'(1)) begin
        ticks_d = ticks_q - TickW'(1);
      end else if (!low_q) begin
        low_d   = 1'b1;
        ticks_d = phase_len(head_byte_i[bit_q], cfg_i.one_low, cfg_i.zero_low);
      end else if (bit_q == '0) begin
        // byte finished: advance the chain to the next byte
        shift = 1'b1;
        bit_d = MsbPos;
        low_d = 1'b0;
        if (byte_q == LastByte) begin
          sending_d = 1'b0;
          byte_d    = '0;
          ticks_d   = '0;
          done      = 1'b1;
        end else begin
          byte_d  = byte_q + BposW'(1);
          ticks_d = phase_len(next_msb_i, cfg_i.one_high, cfg_i.zero_high);
        end
      end else begin
        bit_d   = bit_dec;
        low_d   = 1'b0;
        ticks_d = phase_len(head_byte_i[bit_dec], cfg_i.one_high, cfg_i.zero_high);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      low_q     <= 1'b0;
      bit_q     <= MsbPos;
      byte_q    <= '0;
      ticks_q   <= '0;
    end else begin
      sending_q <= sending_d;
      low_q     <= low_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      ticks_q   <= ticks_d;
    end
  end

  // status towards the top level
  always_comb begin
    status_o.sending   = sending_q;
    status_o.low       = low_q;
    status_o.busy_next = sending_d;
    status_o.done      = done;
    status_o.shift     = shift;
  end

endmodule

`default_nettype wire

>>> rtl/core/rgb_led_strip_serializer.sv
// rgb_led_strip_serializer: top level of the led strip serializer
//
// Drives a WS2812-style strip from a frame store of three colour bytes per led.
// Every input beat gives exactly one output beat in the cycle after it is
// taken, one beat per clock when the output is not stalled; the result register
// takes a new beat in the cycle the last result leaves, and the input stalls
// while a result waits. Each tick beat is one time unit of the waveform, so tick
// beats should arrive every cycle for accurate timing. The store is a chain of
// byte cells: a rotate moves every cell three places at once, and while a
// frame is sent the chain turns by one byte after each byte, so the head cell
// always holds the byte on the line and the store is back in order when the
// frame ends. Write, rotate, clear and start beats are rejected while a frame
// is busy.
`default_nettype none

module rgb_led_strip_serializer #(
  parameter int unsigned LED_COUNT = rls_pkg::LedCountDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  rls_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output rls_pkg::out_item_t            out_data_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [rls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [rls_pkg::TickW-1:0]      cfg_data_i
);
  import rls_pkg::*;

  localparam int unsigned StoreBytes = BytesPerLed * LED_COUNT;
  localparam int unsigned SbW        = $clog2(StoreBytes + 1);
  localparam int unsigned CmpW       = (SbW > IdxW) ? SbW : IdxW;

  logic [7:0]     cell_data [StoreBytes];
  tick_cfg_t      cfg_d, cfg_q;
  tmr_status_t    tmr;
  logic           in_acc;
  logic           out_valid_q;
  out_item_t      out_data_d, out_data_q;
  logic           do_write, do_rotate, do_clear, do_start, do_tick, rej;
  logic [CmpW-1:0] idx_ext;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ZERO_HIGH: cfg_d.zero_high = cfg_data_i;
        CFG_ZERO_LOW:  cfg_d.zero_low  = cfg_data_i;
        CFG_ONE_HIGH:  cfg_d.one_high  = cfg_data_i;
        CFG_ONE_LOW:   cfg_d.one_low   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high <= ZeroHighRst;
      cfg_q.zero_low  <= ZeroLowRst;
      cfg_q.one_high  <= OneHighRst;
      cfg_q.one_low   <= OneLowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_ext    = CmpW'(in_data_i.byte_index);

  // item decode
  always_comb begin
    do_write  = 1'b0;
    do_rotate = 1'b0;
    do_clear  = 1'b0;
    do_start  = 1'b0;
    do_tick   = 1'b0;
    rej       = 1'b0;
    if (in_acc) begin
      if (in_data_i.kind == KIND_TICK) begin
        do_tick = 1'b1;
      end else if (tmr.sending) begin
        rej = 1'b1;
      end else begin
        unique case (in_data_i.kind)
          KIND_WRITE: begin
            if (idx_ext < CmpW'(StoreBytes)) begin
              do_write = 1'b1;
            end else begin
              rej = 1'b1;
            end
          end
          KIND_ROTATE: do_rotate = 1'b1;
          KIND_CLEAR:  do_clear  = 1'b1;
          KIND_START:  do_start  = 1'b1;
          default:     rej       = 1'b1;
        endcase
      end
    end
  end

  // chain of byte cells
  for (genvar i = 0; i < StoreBytes; i++) begin : g_cell
    localparam int unsigned NextByte = (i + 1) % StoreBytes;
    localparam int unsigned NextLed  = (i + BytesPerLed) % StoreBytes;
    cell_ctl_t ctl;

    always_comb begin
      ctl.wr         = do_write && (idx_ext == CmpW'(i));
      ctl.clr        = do_clear;
      ctl.shift_byte = tmr.shift;
      ctl.shift_led  = do_rotate;
    end

    rls_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .wr_data_i   (in_data_i.byte_value),
      .next_byte_i (cell_data[NextByte]),
      .next_led_i  (cell_data[NextLed]),
      .data_o      (cell_data[i])
    );
  end

  // bit sequencer
  rls_timer #(
    .StoreBytes (StoreBytes)
  ) u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (do_start),
    .tick_i      (do_tick),
    .cfg_i       (cfg_q),
    .head_byte_i (cell_data[0]),
    .next_msb_i  (cell_data[1 % StoreBytes][MsbPos]),
    .status_o    (tmr)
  );

  // result beat
  always_comb begin
    out_data_d.line       = do_tick && tmr.sending && !tmr.low;
    out_data_d.busy_res   = tmr.busy_next;
    out_data_d.frame_done = tmr.done;
    out_data_d.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
